### hw/rtl/sha1_message_digest_assert.svh
// Assertion macros for the SHA-1 digest block.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1MD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA1MD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/sha1md_pkg.sv
// Shared types and constants of the SHA-1 digest block.
// Used by the schedule, the round unit and the top level; depends on nothing.
package sha1md_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned NumWords = 5;
	localparam int unsigned Rounds  = 80;

	typedef logic [WordW-1:0] word_t;
	typedef logic [NumWords-1:0][WordW-1:0] chain_t;

	localparam chain_t InitChain = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam word_t K0Default = 32'h5A827999;
	localparam word_t K1Default = 32'h6ED9EBA1;
	localparam word_t K2Default = 32'h8F1BBCDC;
	localparam word_t K3Default = 32'hCA62C1D6;

	localparam logic [7:0] PadMarker = 8'h80;
	localparam logic [5:0] LenStart  = 6'd56;
	localparam logic [5:0] LastByte  = 6'd63;
	localparam logic [6:0] LastRound = 7'd79;
	localparam logic [2:0] LastIndex = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] RegK0 = 2'd0;
	localparam logic [1:0] RegK1 = 2'd1;
	localparam logic [1:0] RegK2 = 2'd2;
	localparam logic [1:0] RegK3 = 2'd3;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       byte_present;
		logic       end_of_message;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	typedef struct packed {
		logic       shift_byte;
		logic       shift_word;
		logic [7:0] byte_in;
	} sched_ctl_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic       add;
		logic       init;
		logic [6:0] rnd;
	} round_ctl_t;

endpackage

### hw/rtl/sha1md_sched.sv
// Block buffer and message schedule of the SHA-1 digest block.
// Bytes shift in one at a time; during compression the sixteen words roll
// and the expanded word is appended. Depends on sha1md_pkg.
module sha1md_sched (
	input  logic                   clk,
	input  sha1md_pkg::sched_ctl_t ctl,
	output sha1md_pkg::word_t      w
);
	import sha1md_pkg::*;

	// Word k of the window sits at bits [511-32k -: 32]; word 0 is the oldest.
	logic [511:0] buf_q;
	word_t        w_next;

	assign w = buf_q[511:480];

	// W[r+16] = rotl1(W[r+13] ^ W[r+8] ^ W[r+2] ^ W[r]).
	always_comb begin
		logic [31:0] x;
		x = buf_q[95:64] ^ buf_q[255:224] ^ buf_q[447:416] ^ buf_q[511:480];
		w_next = {x[30:0], x[31]};
	end

	always_ff @(posedge clk) begin
		if (ctl.shift_byte) begin
			buf_q <= {buf_q[503:0], ctl.byte_in};
		end else if (ctl.shift_word) begin
			buf_q <= {buf_q[479:0], w_next};
		end
	end

endmodule

### hw/rtl/sha1md_round.sv
// Shared round unit of the SHA-1 digest block: working variables a to e,
// one round per cycle, and the five chaining words. Depends on sha1md_pkg.
module sha1md_round (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha1md_pkg::round_ctl_t ctl,
	input  sha1md_pkg::word_t      k,
	input  sha1md_pkg::word_t      w,
	output sha1md_pkg::chain_t     h
);
	import sha1md_pkg::*;

	chain_t h_q;
	word_t  a_q, b_q, c_q, d_q, e_q;
	word_t  f, t;

	assign h = h_q;

	always_comb begin
		if (ctl.rnd < 7'd20) begin
			f = (b_q & c_q) ^ (~b_q & d_q);
		end else if (ctl.rnd >= 7'd40 && ctl.rnd < 7'd60) begin
			f = (b_q & c_q) ^ (b_q & d_q) ^ (c_q & d_q);
		end else begin
			f = b_q ^ c_q ^ d_q;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (ctl.step) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= InitChain;
		end else if (ctl.init) begin
			h_q <= InitChain;
		end else if (ctl.add) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end
	end

endmodule

### hw/rtl/sha1_message_digest.sv
// SHA-1 digest block, top level: sequencer, padding, length counter,
// round constants and output channel. Uses sha1md_pkg, sha1md_sched,
// sha1md_round and the assertion macros.
//
// Usage: message bytes arrive one request at a time on msg (msg_valid,
// msg_stall). A request may carry a byte, an end-of-message mark, or both.
// The block takes a request unless it is busy, and then holds msg_stall
// high. A byte that completes a 64-byte block starts the 80-round
// compression on the single shared round unit, one round a cycle, and then
// folds the result into the chaining words; msg_stall stays high meanwhile.
// At end of message the padding bytes go through the buffer one per cycle,
// then one or two compressions run. The five digest words then leave on dig
// (dig_valid, dig_stall), index 0 first, one per accepted request. While the
// receiver stalls, the current word holds and no message request is taken.
// After the fifth word the block is ready for the next message.
// Reset restores the initial chaining words and the default round
// constants. The user must write round constants on cfg only while the
// block is idle; the block itself does not enforce it.
module sha1_message_digest (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     msg_valid,
	output logic                     msg_stall,
	input  sha1md_pkg::msg_item_t    msg,
	output logic                     dig_valid,
	input  logic                     dig_stall,
	output sha1md_pkg::digest_item_t dig,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [31:0]              cfg_data
);
	import sha1md_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]  state_q;
	logic [5:0]  cnt_q;
	logic [60:0] lenb_q;
	logic [6:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        pad_q, mark_q, lenblk_q, final_q;
	word_t       k0_q, k1_q, k2_q, k3_q;

	sched_ctl_t sctl;
	round_ctl_t rctl;
	word_t      w, kval;
	chain_t     h;
	logic       msg_acc, dig_acc;
	logic [7:0] pad_byte;
	logic [63:0] len_bits;
	logic [2:0]  len_sel;

	assign cfg_ready = 1'b1;
	assign msg_stall = (state_q != ST_IDLE);
	assign msg_acc   = msg_valid && !msg_stall;
	assign dig_valid = (state_q == ST_OUT);
	assign dig_acc   = dig_valid && !dig_stall;

	assign dig.digest_word = h[oidx_q];
	assign dig.word_index  = oidx_q;
	assign dig.last_word   = (oidx_q == LastIndex);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k0_q <= K0Default;
			k1_q <= K1Default;
			k2_q <= K2Default;
			k3_q <= K3Default;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegK0: k0_q <= cfg_data;
				RegK1: k1_q <= cfg_data;
				RegK2: k2_q <= cfg_data;
				RegK3: k3_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rnd_q < 7'd20) begin
			kval = k0_q;
		end else if (rnd_q < 7'd40) begin
			kval = k1_q;
		end else if (rnd_q < 7'd60) begin
			kval = k2_q;
		end else begin
			kval = k3_q;
		end
	end

	// The bit length goes out big-endian in the last eight bytes of the block.
	assign len_bits = {lenb_q, 3'b000};
	assign len_sel  = 3'd7 - cnt_q[2:0];

	always_comb begin
		if (!mark_q) begin
			pad_byte = PadMarker;
		end else if (lenblk_q && cnt_q >= LenStart) begin
			pad_byte = len_bits[{len_sel, 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_comb begin
		sctl     = '0;
		rctl     = '0;
		rctl.rnd = rnd_q;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_acc && msg.byte_present) begin
					sctl.shift_byte = 1'b1;
					sctl.byte_in    = msg.message_byte;
					rctl.load       = (cnt_q == LastByte);
				end
			end
			ST_PAD: begin
				sctl.shift_byte = 1'b1;
				sctl.byte_in    = pad_byte;
				rctl.load       = (cnt_q == LastByte);
			end
			ST_COMP: begin
				rctl.step       = 1'b1;
				sctl.shift_word = 1'b1;
			end
			ST_ADD: begin
				rctl.add = 1'b1;
			end
			ST_OUT: begin
				rctl.init = dig_acc && (oidx_q == LastIndex);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			lenb_q   <= '0;
			rnd_q    <= '0;
			oidx_q   <= '0;
			pad_q    <= 1'b0;
			mark_q   <= 1'b0;
			lenblk_q <= 1'b0;
			final_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						pad_q <= msg.end_of_message;
						if (msg.byte_present) begin
							cnt_q  <= cnt_q + 6'd1;
							lenb_q <= lenb_q + 61'd1;
						end
						if (msg.byte_present && cnt_q == LastByte) begin
							rnd_q   <= '0;
							final_q <= 1'b0;
							state_q <= ST_COMP;
						end else if (msg.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					cnt_q <= cnt_q + 6'd1;
					if (!mark_q) begin
						mark_q   <= 1'b1;
						lenblk_q <= (cnt_q < LenStart);
					end
					if (cnt_q == LastByte) begin
						rnd_q   <= '0;
						final_q <= mark_q && lenblk_q;
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LastRound) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					// A marker block that left no room for the length leads
					// to one more block that carries it.
					if (mark_q) begin
						lenblk_q <= 1'b1;
					end
					if (final_q) begin
						oidx_q  <= '0;
						state_q <= ST_OUT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (dig_acc) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == LastIndex) begin
							cnt_q    <= '0;
							lenb_q   <= '0;
							pad_q    <= 1'b0;
							mark_q   <= 1'b0;
							lenblk_q <= 1'b0;
							final_q  <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	sha1md_sched u_sched (
		.clk (clk),
		.ctl (sctl),
		.w   (w)
	);

	sha1md_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rctl),
		.k      (kval),
		.w      (w),
		.h      (h)
	);

`include "sha1_message_digest_assert.svh"

	`SHA1MD_ASSERT_NOW(a_no_take_while_out, msg_acc, !dig_valid, "request taken during digest output")
	`SHA1MD_ASSERT_NOW(a_round_range, state_q == ST_COMP, rnd_q <= LastRound, "round counter out of range")
	`SHA1MD_ASSERT_NEXT(a_idle_after_last, dig_acc && dig.last_word, !dig_valid && !msg_stall, "block not idle after last digest word")
	`SHA1MD_ASSERT_NOW(a_out_block_aligned, dig_valid, cnt_q == 6'd0, "digest output with partial block buffered")

endmodule

### test/sha1_digest_checker.sv
// Checker for the SHA-1 digest block: watches the message, digest and register
// channels, keeps its own hash state and compares every digest word in order.
// Depends on sha1md_pkg for the request types, the initial words and the constants.
module sha1_digest_checker
	import sha1md_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         msg_valid,
	input  logic         msg_stall,
	input  msg_item_t    msg,
	input  logic         dig_valid,
	input  logic         dig_stall,
	input  digest_item_t dig,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int unsigned  errors,
	output int unsigned  pending,
	output int unsigned  words_seen
);

	word_t        chain [NumWords];
	logic [7:0]   msg_block [64];
	int unsigned  fill;
	logic [63:0]  bit_total;
	word_t        round_k [4];
	digest_item_t expected_words [$];
	digest_item_t want;
	int unsigned  bad;
	int unsigned  seen;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		return (x << n) | (x >> (WordW - n));
	endfunction

	function automatic void restart_message();
		int i;
		for (i = 0; i < NumWords; i++)
			chain[i] = InitChain[i];
		fill = 0;
		bit_total = '0;
	endfunction

	function automatic void compress_block();
		word_t w [Rounds];
		word_t a, b, c, d, e, f, t;
		int    r;
		for (r = 0; r < 16; r++)
			w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
		for (r = 16; r < Rounds; r++)
			w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (r = 0; r < Rounds; r++) begin
			if (r < 20)
				f = (b & c) | (~b & d);
			else if (r >= 40 && r < 60)
				f = (b & c) | (b & d) | (c & d);
			else
				f = b ^ c ^ d;
			t = rotl(a, 5) + f + e + round_k[r / 20] + w[r];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
	endfunction

	function automatic void absorb_byte(input logic [7:0] value);
		msg_block[fill] = value;
		fill++;
		if (fill == 64) begin
			compress_block();
			bit_total += 64'd512;
			fill = 0;
		end
	endfunction

	// Pads the buffered tail, runs the last one or two blocks and queues the
	// five digest words, most significant first.
	function automatic void finish_message();
		int           i;
		int           n;
		logic [63:0]  total;
		digest_item_t word;
		n = fill;
		msg_block[n] = PadMarker;
		for (i = n + 1; i < 64; i++)
			msg_block[i] = 8'h00;
		if (n >= int'(LenStart)) begin
			compress_block();
			for (i = 0; i < int'(LenStart); i++)
				msg_block[i] = 8'h00;
		end
		total = bit_total + 64'(n) * 64'd8;
		for (i = 0; i < 8; i++)
			msg_block[63 - i] = total[8*i +: 8];
		compress_block();
		for (i = 0; i < NumWords; i++) begin
			word.digest_word = chain[i];
			word.word_index  = 3'(i);
			word.last_word   = (3'(i) == LastIndex);
			expected_words.push_back(word);
		end
		restart_message();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_k[0] = K0Default;
			round_k[1] = K1Default;
			round_k[2] = K2Default;
			round_k[3] = K3Default;
			restart_message();
			expected_words.delete();
			bad = 0;
			seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					RegK0: round_k[0] = cfg_data;
					RegK1: round_k[1] = cfg_data;
					RegK2: round_k[2] = cfg_data;
					RegK3: round_k[3] = cfg_data;
					default: ;
				endcase
			end
			if (msg_valid && !msg_stall) begin
				if (msg.byte_present)
					absorb_byte(msg.message_byte);
				if (msg.end_of_message)
					finish_message();
			end
			if (dig_valid && !dig_stall) begin
				seen++;
				if (expected_words.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("unexpected digest word %h index %0d last %0b, none predicted",
							dig.digest_word, dig.word_index, dig.last_word);
				end else begin
					want = expected_words.pop_front();
					if (want.digest_word !== dig.digest_word
							|| want.word_index !== dig.word_index
							|| want.last_word !== dig.last_word) begin
						bad++;
						if (bad <= 10)
							$display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
								want.digest_word, want.word_index, want.last_word,
								dig.digest_word, dig.word_index, dig.last_word);
					end
				end
			end
		end
		errors     <= bad;
		pending    <= expected_words.size();
		words_seen <= seen;
	end

endmodule

### test/tb.sv
// Testbench top for the SHA-1 digest block: drives messages and round constants,
// randomizes idling on both channels and prints the verdict.
// Depends on sha1md_pkg, sha1_message_digest and sha1_digest_checker.
module tb;
	import sha1md_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         msg_valid = 1'b0;
	logic         msg_stall;
	msg_item_t    msg = '0;
	logic         dig_valid;
	logic         dig_stall = 1'b0;
	digest_item_t dig;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = RegK0;
	logic [31:0]  cfg_data = '0;

	int unsigned  errors;
	int unsigned  pending;
	int unsigned  words_seen;
	int unsigned  items_sent = 0;
	int unsigned  eoms_sent = 0;
	int           idle_pct = 38;
	int           stall_pct = 38;

	sha1_message_digest dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sha1_digest_checker digest_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.msg        (msg),
		.dig_valid  (dig_valid),
		.dig_stall  (dig_stall),
		.dig        (dig),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.pending    (pending),
		.words_seen (words_seen)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		dig_stall <= ($urandom_range(99) < stall_pct);
	end

	// Valid drops only after an accepted request, so a held request never changes.
	task automatic send_request(input logic [7:0] value, input logic present, input logic eom);
		while ($urandom_range(99) < idle_pct) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		msg <= '{message_byte: value, byte_present: present, end_of_message: eom};
		@(posedge clk);
		while (msg_stall)
			@(posedge clk);
		if (present || eom)
			items_sent++;
		if (eom)
			eoms_sent++;
	endtask

	task automatic send_message(input int len);
		int   i;
		logic carry;
		carry = ($urandom_range(1) == 1) && (len > 0);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				send_request(8'($urandom_range(255)), 1'b0, 1'b0);
			send_request(8'($urandom_range(255)), 1'b1, carry && (i == len - 1));
		end
		if (!carry)
			send_request(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// Waits for every predicted word, then long enough for a compression that
	// produced no word to finish.
	task automatic drain();
		msg_valid <= 1'b0;
		while (words_seen != 5 * eoms_sent)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic load_constants(input word_t k [4]);
		logic [1:0] reg_ids [4];
		int         i;
		reg_ids = '{RegK0, RegK1, RegK2, RegK3};
		for (i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_ids[i];
			cfg_data  <= k[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		word_t       k_set [4];
		int          boundary_len [5];
		int          phase;
		int          len;
		int unsigned start_items;
		int unsigned start_eoms;

		boundary_len = '{55, 56, 57, 63, 64};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset constants: an ignored empty request, the empty
		// message twice, single bytes at the extremes, "abc" and a two-byte message.
		send_request(8'hA5, 1'b0, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'h00, 1'b1, 1'b1);
		send_request(8'hFF, 1'b1, 1'b0);
		send_request(8'h3C, 1'b0, 1'b0);
		send_request(8'h5A, 1'b0, 1'b1);
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
		send_request(8'hFF, 1'b0, 1'b1);
		send_request(8'h80, 1'b1, 1'b0);
		send_request(8'h7F, 1'b1, 1'b1);
		drain();

		// Random messages under all-zero, all-one, random and standard constants.
		// The all-one phase runs without idling and starts with one message near
		// the block size, so padding just fits, spills into an extra block, or a
		// full block is followed by a padding block.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: k_set = '{32'h0, 32'h0, 32'h0, 32'h0};
				1: k_set = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
				2: k_set = '{$urandom, $urandom, $urandom, $urandom};
				default: k_set = '{K0Default, K1Default, K2Default, K3Default};
			endcase
			load_constants(k_set);
			start_items = items_sent;
			start_eoms = eoms_sent;
			if (phase == 1) begin
				idle_pct = 0;
				stall_pct <= 0;
				send_message(boundary_len[$urandom_range(4)]);
			end
			while (items_sent - start_items < 8 || eoms_sent - start_eoms < 2) begin
				len = $urandom_range(8);
				send_message(len);
			end
			drain();
			idle_pct = 38;
			stall_pct <= 38;
		end

		$display("Sent %0d message requests in %0d messages over five round-constant settings.",
			items_sent, eoms_sent);
		$display("Compared %0d digest words, %0d of them wrong or unexpected.",
			words_seen, errors);
		if (errors == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
